// File: rtl/mphc_pkg.sv
// Shared constants, codes and types of the multi-lane PCG hash chain.
package mphc_pkg;

  localparam int LANES     = 32;
  localparam int MAX_BURST = 64;
  localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_W     = $clog2(MAX_BURST + 1);

  localparam logic [31:0] MUL_A = 32'd747796405;
  localparam logic [31:0] ADD_C = 32'd2891336453;
  localparam logic [31:0] MUL_B = 32'd277803737;

  localparam logic [1:0] ADDR_BYTE_MODE = 2'd0;

  typedef enum logic [1:0] {
    FUNC_DRAW    = 2'd0,
    FUNC_SEED    = 2'd1,
    FUNC_RESTORE = 2'd2
  } func_e;

  // Sideband that travels with each value through the hash stages.
  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic              last;
  } mphc_tag_t;

  // Lanes held in the hash stages, for the same-lane interlock.
  typedef struct packed {
    logic              s_valid;
    logic [LANE_W-1:0] s_lane;
    logic              w_valid;
    logic [LANE_W-1:0] w_lane;
  } mphc_occ_t;

endpackage

// File: rtl/mphc_hash.sv
// Two-stage PCG-RXS-M-XS hash datapath with its sideband tags.
module mphc_hash (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [31:0]          x_i,
  input  mphc_pkg::mphc_tag_t  tag_i,
  output logic                 valid_o,
  output logic [31:0]          h_o,
  output mphc_pkg::mphc_tag_t  tag_o,
  output mphc_pkg::mphc_occ_t  occ_o
);
  import mphc_pkg::*;

  logic        s_valid_q, w_valid_q;
  logic [31:0] s_q, s_d, w_q, w_d;
  mphc_tag_t   s_tag_q, w_tag_q;
  logic [4:0]  sh;
  logic [31:0] t;

  assign s_d = x_i * MUL_A + ADD_C;

  // Data-dependent shift of 4 to 19 bits.
  assign sh  = {1'b0, s_q[31:28]} + 5'd4;
  assign t   = (s_q >> sh) ^ s_q;
  assign w_d = t * MUL_B;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      w_valid_q <= 1'b0;
    end else begin
      s_valid_q <= valid_i;
      w_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    s_tag_q <= tag_i;
    w_q     <= w_d;
    w_tag_q <= s_tag_q;
  end

  assign valid_o = w_valid_q;
  assign h_o     = (w_q >> 22) ^ w_q;
  assign tag_o   = w_tag_q;

  assign occ_o.s_valid = s_valid_q;
  assign occ_o.s_lane  = s_tag_q.lane;
  assign occ_o.w_valid = w_valid_q;
  assign occ_o.w_lane  = w_tag_q.lane;

endmodule

// File: rtl/multi_lane_pcg_hash_chain.sv
// Top level: lane state memory, round-robin sequencer, config port and result register.
// A draw of n values (n saturates at 64; a zero count does nothing) shows its first value
// after the lane read, the two hash stages and the result register, then one value per cycle;
// busy stays high until the read and the two hash stages have drained, so a new draw waits.
// Seed loads and restores give no result. Results cannot be stalled.
// Reset clears per-lane init bits, so every lane reads i+2 at once; no clearing pass.
module multi_lane_pcg_hash_chain (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [6:0]  draw_count_i,
  input  logic [4:0]  seed_lane_i,
  input  logic [31:0] seed_value_i,
  output logic        valid_o,
  output logic [31:0] value_o,
  output logic [4:0]  lane_used_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mphc_pkg::*;

  logic [31:0]       mem [LANES];
  logic [31:0]       rdata_q;
  logic [LANES-1:0]  init_q, init_d;
  logic [LANE_W-1:0] next_q, next_d, next_inc;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              byte_mode_q;
  logic              p1_valid_q, p1_init_q;
  mphc_tag_t         p1_tag_q, p1_tag_d;
  logic              accept, issue, hazard, seed_ok;
  logic              wr_en;
  logic [LANE_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic [31:0]       x;
  logic              h_valid;
  logic [31:0]       h;
  mphc_tag_t         h_tag;
  mphc_occ_t         occ;

  assign accept  = start && !busy;
  assign seed_ok = 32'(seed_lane_i) < LANES;
  assign busy    = (rem_q != '0) || p1_valid_q || occ.s_valid || occ.w_valid;

  // Hold the read while the lane is still in the hash stages.
  assign hazard = (p1_valid_q && (p1_tag_q.lane == next_q)) ||
                  (occ.s_valid && (occ.s_lane == next_q)) ||
                  (occ.w_valid && (occ.w_lane == next_q));
  assign issue  = (rem_q != '0) && !hazard;

  assign next_inc      = (next_q == LANE_W'(LANES - 1)) ? '0 : next_q + 1'b1;
  assign p1_tag_d.lane = next_q;
  assign p1_tag_d.last = (rem_q == CNT_W'(1));

  always_comb begin
    rem_d  = rem_q;
    next_d = next_q;
    init_d = init_q;
    if (issue) begin
      rem_d  = rem_q - 1'b1;
      next_d = next_inc;
    end
    if (h_valid) begin
      init_d[h_tag.lane] = 1'b1;
    end
    if (accept) begin
      case (func_i)
        FUNC_DRAW: begin
          if (32'(draw_count_i) > MAX_BURST) begin
            rem_d = CNT_W'(MAX_BURST);
          end else begin
            rem_d = CNT_W'(draw_count_i);
          end
        end
        FUNC_SEED: begin
          if (seed_ok) begin
            init_d[LANE_W'(seed_lane_i)] = 1'b1;
            next_d = '0;
          end
        end
        FUNC_RESTORE: begin
          init_d = '0;
          next_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    wr_en   = h_valid;
    wr_addr = h_tag.lane;
    wr_data = h;
    if (accept && (func_i == FUNC_SEED) && seed_ok) begin
      wr_en   = 1'b1;
      wr_addr = LANE_W'(seed_lane_i);
      wr_data = seed_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q  <= mem[next_q];
    p1_tag_q <= p1_tag_d;
    p1_init_q <= init_q[next_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      next_q      <= '0;
      init_q      <= '0;
      p1_valid_q  <= 1'b0;
      byte_mode_q <= 1'b0;
      valid_o     <= 1'b0;
    end else begin
      rem_q      <= rem_d;
      next_q     <= next_d;
      init_q     <= init_d;
      p1_valid_q <= issue;
      valid_o    <= h_valid;
      if (psel && penable && pwrite && (paddr == ADDR_BYTE_MODE)) begin
        byte_mode_q <= pwdata[0];
      end
    end
  end

  // A lane never written since reset or restore holds its default seed.
  assign x = p1_init_q ? rdata_q : 32'(p1_tag_q.lane) + 32'd2;

  mphc_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p1_valid_q),
    .x_i     (x),
    .tag_i   (p1_tag_q),
    .valid_o (h_valid),
    .h_o     (h),
    .tag_o   (h_tag),
    .occ_o   (occ)
  );

  always_ff @(posedge clk_i) begin
    value_o     <= byte_mode_q ? {24'd0, h[7:0]} : h;
    lane_used_o <= 5'(h_tag.lane);
    last_o      <= h_tag.last;
  end

  assign prdata = (paddr == ADDR_BYTE_MODE) ? {31'd0, byte_mode_q} : 32'd0;
  assign pready = 1'b1;

  a_no_lane_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q && occ.s_valid |-> p1_tag_q.lane != occ.s_lane)
    else $error("same lane in two hash stages");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("value right after the last of a burst");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("value without a draw in flight");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_valid |-> !accept)
    else $error("item taken while a value is written back");

endmodule

// File: bench/multi_lane_pcg_hash_chain_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the multi-lane PCG hash chain, with its own lane-state predictor.
module multi_lane_pcg_hash_chain_test;
  import mphc_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;  // unassigned code, the block ignores it
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASES       = 5;

  typedef struct packed {
    logic [31:0]       value;
    logic [LANE_W-1:0] lane;
    logic              last;
  } draw_value_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic [1:0]  func_i       = FUNC_DRAW;
  logic [6:0]  draw_count_i = '0;
  logic [4:0]  seed_lane_i  = '0;
  logic [31:0] seed_value_i = '0;
  logic        valid_o;
  logic [31:0] value_o;
  logic [4:0]  lane_used_o;
  logic        last_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [1:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted block state
  logic [31:0]       lane_state [LANES];
  int unsigned       lane_ptr;
  logic              byte_mode_q;
  draw_value_t       pending_values [$];

  int error_count = 0;
  int idle_cycles = 0;
  bit gaps_on     = 1'b1;

  multi_lane_pcg_hash_chain i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .draw_count_i (draw_count_i),
    .seed_lane_i  (seed_lane_i),
    .seed_value_i (seed_value_i),
    .valid_o      (valid_o),
    .value_o      (value_o),
    .lane_used_o  (lane_used_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [31:0] lane_hash(input logic [31:0] x);
    logic [31:0] s;
    logic [4:0]  sh;
    logic [31:0] w;
    s  = x * MUL_A + ADD_C;
    sh = s[31:28] + 5'd4;
    w  = ((s >> sh) ^ s) * MUL_B;
    return (w >> 22) ^ w;
  endfunction

  task automatic restore_lanes();
    for (int i = 0; i < LANES; i++) begin
      lane_state[i] = 32'(i + 2);
    end
    lane_ptr = 0;
  endtask

  // Update the predicted lanes for one taken item and queue the values it draws.
  task automatic advance_lanes(input logic [1:0] func, input logic [6:0] count,
                               input logic [4:0] lane, input logic [31:0] seed);
    int          n;
    int          k;
    int unsigned idx;
    logic [31:0] h;
    draw_value_t d;
    case (func)
      FUNC_SEED: begin
        if (lane < LANES) begin
          lane_state[lane] = seed;
          lane_ptr = 0;
        end
      end
      FUNC_RESTORE: begin
        restore_lanes();
      end
      FUNC_DRAW: begin
        n = (count > MAX_BURST) ? MAX_BURST : int'(count);
        for (k = 0; k < n; k++) begin
          idx = (lane_ptr >= LANES) ? 0 : lane_ptr;
          h = lane_hash(lane_state[idx]);
          lane_state[idx] = h;
          d.value = byte_mode_q ? {24'd0, h[7:0]} : h;
          d.lane  = LANE_W'(idx);
          d.last  = (k == n - 1);
          pending_values.push_back(d);
          lane_ptr = (idx + 1 >= LANES) ? 0 : idx + 1;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one item, hold it until taken, then predict it.
  task automatic send_item(input logic [1:0] func, input logic [6:0] count,
                           input logic [4:0] lane, input logic [31:0] seed);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        <= 1'b1;
    func_i       <= func;
    draw_count_i <= count;
    seed_lane_i  <= lane;
    seed_value_i <= seed;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    advance_lanes(func, count, lane, seed);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk_i);
    // seed loads and zero draws leave nothing to wait for, so let them settle
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_byte_mode(input logic mode);
    logic [31:0] data;
    data    = $urandom();
    data[0] = mode;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BYTE_MODE;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    byte_mode_q = data[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_byte_mode_readback();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_BYTE_MODE;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {31'd0, byte_mode_q}) begin
      $error("byte_mode: expected %h, actual %h", {31'd0, byte_mode_q}, prdata);
      error_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A single value, a full burst, a zero draw and oversized draws from the reset seeds.
  task automatic test_default_seeds();
    send_item(FUNC_DRAW, 7'd1, 5'($urandom()), $urandom());
    send_item(FUNC_DRAW, 7'd64, 5'($urandom()), $urandom());
    send_item(FUNC_DRAW, 7'd0, 5'($urandom()), $urandom());
    send_item(FUNC_DRAW, 7'd127, 5'($urandom()), $urandom());
    send_item(FUNC_DRAW, 7'd65, 5'($urandom()), $urandom());
  endtask

  task automatic test_seed_loads();
    send_item(FUNC_SEED, 7'($urandom()), 5'd0, 32'h0000_0000);
    send_item(FUNC_SEED, 7'($urandom()), 5'd31, 32'hFFFF_FFFF);
    send_item(FUNC_SEED, 7'($urandom()), 5'd17, $urandom());
    send_item(FUNC_DRAW, 7'd32, 5'($urandom()), $urandom());
    send_item(FUNC_DRAW, 7'd2, 5'($urandom()), $urandom());
    send_item(FUNC_RESTORE, 7'($urandom()), 5'($urandom()), $urandom());
    send_item(FUNC_DRAW, 7'd3, 5'($urandom()), $urandom());
    send_item(FUNC_NONE, 7'd5, 5'($urandom()), $urandom());
    send_item(FUNC_DRAW, 7'd1, 5'($urandom()), $urandom());
  endtask

  task automatic test_byte_mode();
    wait_idle();
    write_byte_mode(1'b1);
    check_byte_mode_readback();
    send_item(FUNC_DRAW, 7'd5, 5'($urandom()), $urandom());
    send_item(FUNC_SEED, 7'($urandom()), 5'd3, $urandom());
    send_item(FUNC_DRAW, 7'd4, 5'($urandom()), $urandom());
    wait_idle();
    write_byte_mode(1'b0);
    check_byte_mode_readback();
    send_item(FUNC_DRAW, 7'd2, 5'($urandom()), $urandom());
  endtask

  task automatic test_random_traffic();
    int          phase;
    int          sent;
    int          r;
    logic [1:0]  func;
    logic [6:0]  count;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      write_byte_mode((phase == PHASES - 1) ? 1'($urandom_range(0, 1)) : phase[0]);
      check_byte_mode_readback();
      gaps_on = (phase != 2);  // one phase runs items back to back
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        r = $urandom_range(0, 99);
        if (r < 72) func = FUNC_DRAW;
        else if (r < 86) func = FUNC_SEED;
        else if (r < 93) func = FUNC_RESTORE;
        else func = FUNC_NONE;
        r = $urandom_range(0, 99);
        if (r < 72) count = 7'($urandom_range(1, 8));
        else if (r < 92) count = 7'($urandom_range(9, 64));
        else if (r < 95) count = 7'd0;
        else count = 7'($urandom_range(65, 127));
        send_item(func, count, 5'($urandom()), $urandom());
        if (func != FUNC_NONE && !(func == FUNC_DRAW && count == 0)) sent++;
      end
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    draw_value_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_values.size() == 0) begin
        $error("value: expected none, actual %h (lane %0d)", value_o, lane_used_o);
        error_count++;
      end else begin
        want = pending_values.pop_front();
        if (value_o !== want.value) begin
          $error("value: expected %h, actual %h", want.value, value_o);
          error_count++;
        end
        if (lane_used_o !== want.lane) begin
          $error("lane_used: expected %0d, actual %0d", want.lane, lane_used_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, actual %b", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no item taken, no value out and no register access.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o === 1'b1 || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("multi_lane_pcg_hash_chain verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    restore_lanes();
    byte_mode_q = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_byte_mode_readback();
    test_default_seeds();
    test_seed_loads();
    test_byte_mode();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("multi_lane_pcg_hash_chain verification clean");
    end else begin
      $display("multi_lane_pcg_hash_chain verification failed");
    end
    $finish;
  end

endmodule
